>>> hw/rtl/sqf_pkg.sv
// ----------------------------------------------------------------------------
// sqf_pkg
// Shared types and constants of the sliding quadratic fit rate estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package sqf_pkg;

  typedef enum logic {
    CFG_STEP = 1'b0,
    CFG_WIN  = 1'b1
  } cfg_idx_t;

  localparam logic [7:0] STEP_RESET = 8'd10;
  localparam logic [7:0] WIN_RESET  = 8'd101;
  localparam int         MIN_FIT    = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_PREP,
    ST_SET,
    ST_SETW,
    ST_FINIT,
    ST_FRD,
    ST_FMUL,
    ST_FWAIT,
    ST_DIV,
    ST_DIVW,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    SET_P1,
    SET_W0,
    SET_D0,
    SET_N1,
    SET_N2,
    SET_N3,
    SET_N4,
    SET_DEN
  } setop_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic neg;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sliding_quadratic_fit_rate.sv
// ----------------------------------------------------------------------------
// sliding_quadratic_fit_rate
// Each unpaused tick whose frame number is a multiple of step_frames stores
// the (A, B) counter pair in a window of up to window_len samples; every
// unpaused tick then returns the endpoint slope of a least-squares quadratic
// fit per channel, unsigned Q16.16 per frame. A paused tick is accepted and
// gives no result. An unpaused tick waits while the result register stays
// full. The step test and each channel's final division run on a bit-serial
// divider, and every sample of each channel passes through the single shared
// multiply-accumulate unit. A channel whose sum is not positive skips its
// division; with fewer than three samples the fit is skipped.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_quadratic_fit_rate #(
  parameter int MAX_WINDOW  = 128,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_paused,
  input  wire logic [31:0] in_frame_number,
  input  wire logic [23:0] in_total_a,
  input  wire logic [23:0] in_total_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_rate_a,
  output logic [31:0]      out_rate_b,
  output logic             out_fit_valid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int NB   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SB   = SAMPLE_BITS;
  localparam int WB   = 3 * NB + 7;
  localparam int CW   = (WB + 1) / 2;
  localparam int MW   = 2 * CW;
  localparam int ACCW = 4 * NB + 8 + SB;
  localparam int DENW = 5 * NB + 8;
  localparam int PW   = (ACCW > DENW + 1) ? ACCW : DENW + 1;
  localparam int DIVW = PW + 16;
  localparam int LW   = (NB > 8) ? NB : 8;
  localparam int CNW  = NB + 1;

  sqf_pkg::state_t state_r, state_nxt;
  sqf_pkg::setop_t setop_r, setop_nxt;
  logic [7:0]         step_r, step_nxt;
  logic [7:0]         win_r, win_nxt;
  logic [NB-1:0]      count_r, count_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [SB-1:0]      ya_r, ya_nxt;
  logic [SB-1:0]      yb_r, yb_nxt;
  logic [NB-1:0]      n_r, n_nxt;
  logic [31:0]        t1_r, t1_nxt;
  logic [31:0]        t2_r, t2_nxt;
  logic [DENW-1:0]    den_r, den_nxt;
  logic signed [WB:0] w0_r, w0_nxt;
  logic signed [WB:0] d0_r, d0_nxt;
  logic signed [WB:0] w_r, w_nxt;
  logic signed [WB:0] d_r, d_nxt;
  logic [NB-1:0]      k_r, k_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               ch_r, ch_nxt;
  logic [31:0]        rate_a_r, rate_a_nxt;
  logic [31:0]        rate_b_r, rate_b_nxt;
  logic               fitv_r, fitv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_rate_a_r, out_rate_a_nxt;
  logic [31:0]        out_rate_b_r, out_rate_b_nxt;
  logic               out_fit_valid_r, out_fit_valid_nxt;

  logic [7:0]         step_eff;
  logic [LW-1:0]      win_ext;
  logic [NB-1:0]      lim;
  logic [CNW-1:0]     cinc;
  logic [NB-1:0]      count_inc;
  logic [NB-1:0]      n_cur;
  logic [CNW-1:0]     osum;
  logic [AW-1:0]      oldest;
  logic [AW-1:0]      slot_inc;
  logic [AW-1:0]      addr_inc;
  logic [WB:0]        r_ext;
  logic [WB:0]        m_ext;
  logic signed [WB:0] dd;
  logic signed [WB:0] w_abs;
  logic [MW-1:0]      nb;
  logic [31:0]        na;
  logic [SB-1:0]      y_sel;
  logic               acc_pos;
  logic [31:0]        rate_sat;

  logic                     ram_we;
  logic [2*SB-1:0]          ram_rdata;
  sqf_pkg::mac_ctl_t        mac_ctl;
  logic [31:0]              mac_a;
  logic [MW-1:0]            mac_b;
  logic                     mac_done;
  logic signed [PW-1:0]     mac_acc;
  logic                     div_start;
  logic [DIVW-1:0]          div_dvd;
  logic [DENW-1:0]          div_dvs;
  logic                     div_done;
  logic [DIVW-1:0]          div_quot;
  logic [DENW-1:0]          div_rem;

  sqf_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({yb_r, ya_r}),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  sqf_mac #(
    .CW (CW),
    .PW (PW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  sqf_div #(
    .DW (DIVW),
    .VW (DENW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign step_eff = (step_r == 8'd0) ? 8'd1 : step_r;
  assign win_ext  = LW'(win_r);

  always_comb begin
    if (win_ext > LW'(MAX_WINDOW)) begin
      lim = NB'(MAX_WINDOW);
    end else if (win_r == 8'd0) begin
      lim = NB'(1);
    end else begin
      lim = NB'(win_ext);
    end
  end

  assign cinc      = CNW'(count_r) + CNW'(1);
  assign count_inc = (cinc > CNW'(lim)) ? lim : NB'(cinc);
  assign n_cur     = (count_r < lim) ? count_r : lim;
  assign osum      = CNW'(slot_r) + CNW'(MAX_WINDOW) - CNW'(n_r);
  assign oldest    = (osum >= CNW'(MAX_WINDOW)) ? AW'(osum - CNW'(MAX_WINDOW)) : AW'(osum);
  assign slot_inc  = (slot_r == AW'(MAX_WINDOW - 1)) ? '0 : slot_r + AW'(1);
  assign addr_inc  = (addr_r == AW'(MAX_WINDOW - 1)) ? '0 : addr_r + AW'(1);
  assign r_ext     = {1'b0, mac_acc[WB-1:0]};
  assign m_ext     = (WB + 1)'(n_r) - (WB + 1)'(1);
  assign dd        = signed'((m_ext << 8) + (m_ext << 6) + (m_ext << 5) + (m_ext << 3));
  assign w_abs     = w_r[WB] ? -w_r : w_r;
  assign nb        = MW'(n_r);
  assign na        = 32'(n_r);
  assign y_sel     = ch_r ? ram_rdata[2*SB-1:SB] : ram_rdata[SB-1:0];
  assign acc_pos   = !mac_acc[PW-1] && (mac_acc != '0);
  assign rate_sat  = (|div_quot[DIVW-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];

  always_comb begin
    state_nxt         = state_r;
    setop_nxt         = setop_r;
    step_nxt          = step_r;
    win_nxt           = win_r;
    count_nxt         = count_r;
    slot_nxt          = slot_r;
    ya_nxt            = ya_r;
    yb_nxt            = yb_r;
    n_nxt             = n_r;
    t1_nxt            = t1_r;
    t2_nxt            = t2_r;
    den_nxt           = den_r;
    w0_nxt            = w0_r;
    d0_nxt            = d0_r;
    w_nxt             = w_r;
    d_nxt             = d_r;
    k_nxt             = k_r;
    addr_nxt          = addr_r;
    ch_nxt            = ch_r;
    rate_a_nxt        = rate_a_r;
    rate_b_nxt        = rate_b_r;
    fitv_nxt          = fitv_r;
    out_valid_nxt     = out_valid_r;
    out_rate_a_nxt    = out_rate_a_r;
    out_rate_b_nxt    = out_rate_b_r;
    out_fit_valid_nxt = out_fit_valid_r;
    ram_we            = 1'b0;
    mac_ctl           = '0;
    mac_a             = '0;
    mac_b             = '0;
    div_start         = 1'b0;
    div_dvd           = DIVW'(in_frame_number);
    div_dvs           = DENW'(step_eff);

    if (cfg_valid) begin
      unique case (sqf_pkg::cfg_idx_t'(cfg_index))
        sqf_pkg::CFG_STEP: step_nxt = cfg_data;
        sqf_pkg::CFG_WIN:  win_nxt  = cfg_data;
        default:           step_nxt = step_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      sqf_pkg::ST_IDLE: begin
        if (in_valid && !in_paused) begin
          ya_nxt    = SB'(in_total_a);
          yb_nxt    = SB'(in_total_b);
          div_start = 1'b1;
          state_nxt = sqf_pkg::ST_MOD;
        end
      end
      sqf_pkg::ST_MOD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            ram_we    = 1'b1;
            slot_nxt  = slot_inc;
            count_nxt = count_inc;
          end
          state_nxt = sqf_pkg::ST_PREP;
        end
      end
      sqf_pkg::ST_PREP: begin
        n_nxt = n_cur;
        if (n_cur < NB'(sqf_pkg::MIN_FIT)) begin
          rate_a_nxt = '0;
          rate_b_nxt = '0;
          fitv_nxt   = 1'b0;
          state_nxt  = sqf_pkg::ST_FIN;
        end else begin
          fitv_nxt  = 1'b1;
          setop_nxt = sqf_pkg::SET_P1;
          state_nxt = sqf_pkg::ST_SET;
        end
      end
      sqf_pkg::ST_SET: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clr   = 1'b1;
        unique case (setop_r)
          sqf_pkg::SET_P1: begin
            mac_a = na - 32'd1;
            mac_b = nb - MW'(2);
          end
          sqf_pkg::SET_W0: begin
            mac_a = t1_r;
            mac_b = (nb << 2) - MW'(7);
          end
          sqf_pkg::SET_D0: begin
            mac_a = na - 32'd2;
            mac_b = (nb << 4) - (nb << 1) - MW'(17);
          end
          sqf_pkg::SET_N1: begin
            mac_a = na;
            mac_b = nb - MW'(1);
          end
          sqf_pkg::SET_N2: begin
            mac_a = t1_r;
            mac_b = nb + MW'(1);
          end
          sqf_pkg::SET_N3: begin
            mac_a = na - 32'd2;
            mac_b = nb + MW'(2);
          end
          sqf_pkg::SET_N4: begin
            mac_a = t1_r;
            mac_b = MW'(step_eff);
          end
          sqf_pkg::SET_DEN: begin
            mac_a = t2_r;
            mac_b = MW'(t1_r);
          end
          default: mac_a = '0;
        endcase
        state_nxt = sqf_pkg::ST_SETW;
      end
      sqf_pkg::ST_SETW: begin
        if (mac_done) begin
          state_nxt = sqf_pkg::ST_SET;
          unique case (setop_r)
            sqf_pkg::SET_P1: begin
              t1_nxt    = 32'(mac_acc);
              setop_nxt = sqf_pkg::SET_W0;
            end
            sqf_pkg::SET_W0: begin
              w0_nxt    = signed'((r_ext << 2) + (r_ext << 1));
              setop_nxt = sqf_pkg::SET_D0;
            end
            sqf_pkg::SET_D0: begin
              d0_nxt    = signed'(-((r_ext << 3) + (r_ext << 2)));
              setop_nxt = sqf_pkg::SET_N1;
            end
            sqf_pkg::SET_N1: begin
              t1_nxt    = 32'(mac_acc);
              setop_nxt = sqf_pkg::SET_N2;
            end
            sqf_pkg::SET_N2: begin
              t2_nxt    = 32'(mac_acc);
              setop_nxt = sqf_pkg::SET_N3;
            end
            sqf_pkg::SET_N3: begin
              t1_nxt    = 32'(mac_acc);
              setop_nxt = sqf_pkg::SET_N4;
            end
            sqf_pkg::SET_N4: begin
              t1_nxt    = 32'(mac_acc);
              setop_nxt = sqf_pkg::SET_DEN;
            end
            sqf_pkg::SET_DEN: begin
              den_nxt   = DENW'(mac_acc);
              ch_nxt    = 1'b0;
              state_nxt = sqf_pkg::ST_FINIT;
            end
            default: state_nxt = sqf_pkg::ST_IDLE;
          endcase
        end
      end
      sqf_pkg::ST_FINIT: begin
        w_nxt       = w0_r;
        d_nxt       = d0_r;
        k_nxt       = '0;
        addr_nxt    = oldest;
        mac_ctl.clr = 1'b1;
        state_nxt   = sqf_pkg::ST_FRD;
      end
      sqf_pkg::ST_FRD: begin
        state_nxt = sqf_pkg::ST_FMUL;
      end
      sqf_pkg::ST_FMUL: begin
        mac_ctl.start = 1'b1;
        mac_ctl.neg   = w_r[WB];
        mac_a         = 32'(y_sel);
        mac_b         = MW'(w_abs[WB-1:0]);
        state_nxt     = sqf_pkg::ST_FWAIT;
      end
      sqf_pkg::ST_FWAIT: begin
        if (mac_done) begin
          w_nxt    = w_r + d_r;
          d_nxt    = d_r + dd;
          k_nxt    = k_r + NB'(1);
          addr_nxt = addr_inc;
          if (k_r == n_r - NB'(1)) begin
            state_nxt = sqf_pkg::ST_DIV;
          end else begin
            state_nxt = sqf_pkg::ST_FRD;
          end
        end
      end
      sqf_pkg::ST_DIV: begin
        if (acc_pos) begin
          div_start = 1'b1;
          div_dvd   = DIVW'({mac_acc[PW-2:0], 16'h0000});
          div_dvs   = den_r;
          state_nxt = sqf_pkg::ST_DIVW;
        end else begin
          if (ch_r) begin
            rate_b_nxt = '0;
            state_nxt  = sqf_pkg::ST_FIN;
          end else begin
            rate_a_nxt = '0;
            ch_nxt     = 1'b1;
            state_nxt  = sqf_pkg::ST_FINIT;
          end
        end
      end
      sqf_pkg::ST_DIVW: begin
        if (div_done) begin
          if (ch_r) begin
            rate_b_nxt = rate_sat;
            state_nxt  = sqf_pkg::ST_FIN;
          end else begin
            rate_a_nxt = rate_sat;
            ch_nxt     = 1'b1;
            state_nxt  = sqf_pkg::ST_FINIT;
          end
        end
      end
      sqf_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_rate_a_nxt    = rate_a_r;
          out_rate_b_nxt    = rate_b_r;
          out_fit_valid_nxt = fitv_r;
          state_nxt         = sqf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sqf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqf_pkg::ST_IDLE;
      step_r      <= sqf_pkg::STEP_RESET;
      win_r       <= sqf_pkg::WIN_RESET;
      count_r     <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      win_r       <= win_nxt;
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    setop_r         <= setop_nxt;
    ya_r            <= ya_nxt;
    yb_r            <= yb_nxt;
    n_r             <= n_nxt;
    t1_r            <= t1_nxt;
    t2_r            <= t2_nxt;
    den_r           <= den_nxt;
    w0_r            <= w0_nxt;
    d0_r            <= d0_nxt;
    w_r             <= w_nxt;
    d_r             <= d_nxt;
    k_r             <= k_nxt;
    addr_r          <= addr_nxt;
    ch_r            <= ch_nxt;
    rate_a_r        <= rate_a_nxt;
    rate_b_r        <= rate_b_nxt;
    fitv_r          <= fitv_nxt;
    out_rate_a_r    <= out_rate_a_nxt;
    out_rate_b_r    <= out_rate_b_nxt;
    out_fit_valid_r <= out_fit_valid_nxt;
  end

  assign in_ready      = (state_r == sqf_pkg::ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_rate_a    = out_rate_a_r;
  assign out_rate_b    = out_rate_b_r;
  assign out_fit_valid = out_fit_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/sqf_ram.sv
// ----------------------------------------------------------------------------
// sqf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sqf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/sqf_mac.sv
// ----------------------------------------------------------------------------
// sqf_mac
// Shared multiply-accumulate unit: 32-bit operand times a two-digit operand,
// one digit product per cycle, added or subtracted into a signed accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sqf_mac #(
  parameter int CW = 16,
  parameter int PW = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sqf_pkg::mac_ctl_t    ctl,
  input  wire logic [31:0]          a,
  input  wire logic [2*CW-1:0]      b,
  output logic                      done,
  output logic signed [PW-1:0]      acc
);

  typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_ADD} mph_t;

  mph_t              ph_r;
  logic              done_r;
  logic [31:0]       a_r;
  logic [2*CW-1:0]   b_r;
  logic              neg_r;
  logic [31+CW:0]    prod_r;
  logic [CW-1:0]     digit;
  logic [PW-1:0]     term;
  logic signed [PW-1:0] acc_r;

  assign digit = (ph_r == MP_LO) ? b_r[CW-1:0] : b_r[2*CW-1:CW];
  assign term  = (ph_r == MP_ADD) ? (PW'(prod_r) << CW) : PW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (ph_r == MP_ADD);
      unique case (ph_r)
        MP_IDLE: if (ctl.start) ph_r <= MP_LO;
        MP_LO:   ph_r <= MP_HI;
        MP_HI:   ph_r <= MP_ADD;
        MP_ADD:  ph_r <= MP_IDLE;
        default: ph_r <= MP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= a;
      b_r   <= b;
      neg_r <= ctl.neg;
    end
    prod_r <= a_r * digit;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ph_r == MP_HI || ph_r == MP_ADD) begin
      acc_r <= neg_r ? acc_r - signed'(term) : acc_r + signed'(term);
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/sqf_div.sv
// ----------------------------------------------------------------------------
// sqf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sqf_div #(
  parameter int DW = 80,
  parameter int VW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [VW-1:0]      rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DW-1:0]   dvd_r;
  logic [DW-1:0]   quot_r;
  logic [VW-1:0]   dvs_r;
  logic [VW-1:0]   rem_r;
  logic [VW:0]     sh;
  logic [VW:0]     diff;
  logic            ge;

  assign sh   = {rem_r, dvd_r[DW-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNTW'(1));
      if (start) begin
        cnt_r <= CNTW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= ge ? diff[VW-1:0] : sh[VW-1:0];
      quot_r <= {quot_r[DW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> tb/sliding_quadratic_fit_rate_test.sv
// ----------------------------------------------------------------------------
// sliding_quadratic_fit_rate_test
// Drives ticks through the rate estimator under several step and window
// settings, predicts each fitted slope exactly in wide integers, and checks
// every result transfer in order against the predicted rates and fit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_quadratic_fit_rate_test;

  localparam int RING_DEPTH = 128;
  localparam int STALL_LIMIT = 20000;
  localparam int TICK_CAP = 2048;
  localparam int CFG_CAP = 64;

  typedef struct {
    logic        paused;
    logic [31:0] frame;
    logic [23:0] tot_a;
    logic [23:0] tot_b;
  } tick_t;

  typedef struct {
    logic [31:0] rate_a;
    logic [31:0] rate_b;
    logic        fit_valid;
  } rate_t;

  typedef struct {
    sqf_pkg::cfg_idx_t idx;
    logic [7:0]        data;
  } cfg_wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_paused = 1'b0;
  logic [31:0] in_frame_number = '0;
  logic [23:0] in_total_a = '0;
  logic [23:0] in_total_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_rate_a;
  logic [31:0] out_rate_b;
  logic out_fit_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  sqf_pkg::cfg_idx_t cfg_index = sqf_pkg::CFG_STEP;
  logic [7:0] cfg_data = '0;

  sliding_quadratic_fit_rate u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_paused(in_paused),
    .in_frame_number(in_frame_number), .in_total_a(in_total_a),
    .in_total_b(in_total_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_rate_a(out_rate_a),
    .out_rate_b(out_rate_b), .out_fit_valid(out_fit_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tick_t   tick_buf[TICK_CAP];
  int      tick_wr = 0;
  int      tick_rd = 0;
  rate_t   rate_buf[TICK_CAP];
  int      rate_wr = 0;
  int      rate_rd = 0;
  cfg_wr_t cfg_buf[CFG_CAP];
  int      cfg_wr = 0;
  int      cfg_rd = 0;
  int      err_cnt = 0;

  // predictor state
  logic [7:0]  step_reg = sqf_pkg::STEP_RESET;
  logic [7:0]  win_reg  = sqf_pkg::WIN_RESET;
  logic [23:0] hist_a[RING_DEPTH];
  logic [23:0] hist_b[RING_DEPTH];
  int          hist_cnt = 0;
  int          hist_slot = 0;

  function automatic logic [31:0] fit_rate(input bit chan_b, input int n, input int stp);
    logic signed [127:0] acc, wv, yv, den, q;
    longint signed u, w, nn;
    int oldest;
    acc = '0;
    nn = n;
    oldest = (hist_slot + RING_DEPTH - n) % RING_DEPTH;
    for (int k = 0; k < n; k++) begin
      u = 2 * k - (nn - 1);
      w = 6 * u * (nn * nn - 4) + 15 * (nn - 1) * (3 * u * u - nn * nn + 1);
      wv = w;
      yv = chan_b ? hist_b[(oldest + k) % RING_DEPTH] : hist_a[(oldest + k) % RING_DEPTH];
      acc = acc + wv * yv;
    end
    if (acc <= 0) return 32'd0;
    den = nn * (nn * nn - 1) * (nn * nn - 4) * stp;
    q = (acc <<< 16) / den;
    if (q > 128'sh0FFFF_FFFF) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  task automatic predict_tick(input tick_t t);
    int stp, lim, n;
    rate_t r;
    stp = (step_reg == 0) ? 1 : step_reg;
    lim = (win_reg > RING_DEPTH) ? RING_DEPTH : ((win_reg == 0) ? 1 : win_reg);
    if (t.paused) return;
    if (t.frame % stp == 0) begin
      hist_a[hist_slot] = t.tot_a;
      hist_b[hist_slot] = t.tot_b;
      hist_slot = (hist_slot + 1) % RING_DEPTH;
      hist_cnt = hist_cnt + 1;
      if (hist_cnt > lim) hist_cnt = lim;
    end
    n = (hist_cnt < lim) ? hist_cnt : lim;
    if (n < sqf_pkg::MIN_FIT) begin
      r = '{32'd0, 32'd0, 1'b0};
    end else begin
      r = '{fit_rate(1'b0, n, stp), fit_rate(1'b1, n, stp), 1'b1};
    end
    rate_buf[rate_wr] = r;
    rate_wr++;
  endtask

  // input driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) predict_tick('{in_paused, in_frame_number, in_total_a, in_total_b});
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (tick_rd < tick_wr) begin
        t = tick_buf[tick_rd];
        tick_rd++;
        in_valid <= 1'b1;
        in_paused <= t.paused;
        in_frame_number <= t.frame;
        in_total_a <= t.tot_a;
        in_total_b <= t.tot_b;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // config driver
  always @(posedge clk) begin
    cfg_wr_t c;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sqf_pkg::CFG_STEP) step_reg = cfg_data;
        else win_reg = cfg_data;
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_rd < cfg_wr) begin
          c = cfg_buf[cfg_rd];
          cfg_rd++;
          cfg_valid <= 1'b1;
          cfg_index <= c.idx;
          cfg_data <= c.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with its own stall pattern, and checker
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    rate_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rate_rd == rate_wr) begin
          $error("result transfer with nothing expected");
          err_cnt++;
        end else begin
          e = rate_buf[rate_rd];
          rate_rd++;
          if (out_rate_a !== e.rate_a) begin
            $error("rate_a expected %h actual %h", e.rate_a, out_rate_a);
            err_cnt++;
          end
          if (out_rate_b !== e.rate_b) begin
            $error("rate_b expected %h actual %h", e.rate_b, out_rate_b);
            err_cnt++;
          end
          if (out_fit_valid !== e.fit_valid) begin
            $error("fit_valid expected %b actual %b", e.fit_valid, out_fit_valid);
            err_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  logic [31:0] gen_frame = 0;
  logic [23:0] gen_a = 0;
  logic [23:0] gen_b = 0;

  task automatic add_tick(input logic p, input logic [31:0] f, input logic [23:0] a,
                          input logic [23:0] b);
    tick_buf[tick_wr] = '{p, f, a, b};
    tick_wr++;
  endtask

  task automatic gen_ticks(input int count, input int stp);
    int r, grow_a, grow_b;
    grow_a = 50;
    grow_b = 50;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r % 16 == 0) begin
        grow_a = (r < 50) ? $urandom_range(0, 3) : $urandom_range(0, 70000);
        grow_b = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 4000000);
      end
      if (r < 8) begin
        add_tick(1'b1, $urandom, 24'($urandom), 24'($urandom));
      end else if (r < 16) begin
        add_tick(1'b0, $urandom, 24'($urandom), 24'($urandom));
      end else begin
        gen_frame = gen_frame + ((r < 26) ? $urandom_range(1, 3) : ((stp == 0) ? 1 : stp));
        if (r < 32) gen_a = gen_a - 24'($urandom_range(0, grow_a));
        else gen_a = gen_a + 24'($urandom_range(0, grow_a));
        gen_b = gen_b + 24'($urandom_range(0, grow_b));
        add_tick(1'b0, gen_frame, gen_a, gen_b);
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (tick_rd < tick_wr || in_valid || rate_rd < rate_wr || cfg_rd < cfg_wr ||
           cfg_valid);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_cfg(input logic [7:0] stp, input logic [7:0] win);
    cfg_buf[cfg_wr] = '{sqf_pkg::CFG_STEP, stp};
    cfg_wr++;
    cfg_buf[cfg_wr] = '{sqf_pkg::CFG_WIN, win};
    cfg_wr++;
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: paused, too few samples, frame extremes
    add_tick(1'b1, 32'd0, 24'hFFFFFF, 24'hFFFFFF);
    add_tick(1'b0, 32'd0, 24'd0, 24'hFFFFFF);
    add_tick(1'b0, 32'd5, 24'd1, 24'd1);
    add_tick(1'b0, 32'd10, 24'h000100, 24'hFFFFF0);
    add_tick(1'b0, 32'd4294967290, 24'h000300, 24'hFFFFE0);
    add_tick(1'b0, 32'hFFFFFFFF, 24'd0, 24'd0);
    gen_frame = 0;
    gen_ticks(30, 10);
    settle();

    // smallest fitting window, unit step: saturation and negative slope
    set_cfg(8'd1, 8'd3);
    add_tick(1'b0, 32'd1, 24'd0, 24'hFFFFFF);
    add_tick(1'b0, 32'd2, 24'd0, 24'h800000);
    add_tick(1'b0, 32'd3, 24'hFFFFFF, 24'd0);
    add_tick(1'b0, 32'd4, 24'hFFFFFF, 24'd0);
    add_tick(1'b0, 32'd5, 24'hFFFFFF, 24'd0);
    add_tick(1'b1, 32'd6, 24'd0, 24'd0);
    add_tick(1'b0, 32'd7, 24'h7FFFFF, 24'h000001);
    gen_ticks(140, 1);
    settle();

    // zero step and zero window
    set_cfg(8'd0, 8'd0);
    gen_ticks(40, 1);
    settle();

    // largest step, window beyond the ring
    set_cfg(8'd255, 8'd255);
    gen_frame = 0;
    gen_ticks(160, 255);
    settle();

    // window shrunk
    set_cfg(8'd255, 8'd5);
    gen_ticks(80, 255);
    settle();

    set_cfg(8'd7, 8'd16);
    gen_frame = 0;
    gen_ticks(280, 7);
    settle();

    set_cfg(8'd2, 8'd40);
    gen_ticks(250, 2);
    settle();

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
